/* sv/ptpf_pkg.sv */
package ptpf_pkg;

    typedef enum logic [2:0] {
        POL_ON_CHANGE    = 3'd0,
        POL_ON_THRESHOLD = 3'd1,
        POL_PERIODIC     = 3'd2,
        POL_CONTINUOUS   = 3'd3,
        POL_ON_UPDATE    = 3'd4
    } t_policy;

    // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT, exact for x < 2^32
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef struct packed {
        logic [2:0]         policy;
        logic [23:0]        period;
        logic [30:0]        thr;
        logic signed [31:0] analog;
        logic [7:0]         level;
        logic [31:0]        now;
    } t_sample;

    typedef struct packed {
        logic [7:0]         level;
        logic signed [31:0] analog;
        logic [31:0]        stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* sv/ptpf_ram.sv */
module ptpf_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 32
    )
    (
        input  logic                                  i_clk,
        input  logic                                  i_we,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
        input  logic [WIDTH-1:0]                      i_wdata,
        input  logic                                  i_re,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
        output logic [WIDTH-1:0]                      o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ptpf_decide.sv */
module ptpf_decide
    import ptpf_pkg::*;
    (
        input  t_sample     i_smp,
        input  logic [23:0] i_limit,
        input  logic        i_ever,
        input  t_entry      i_cur,
        output logic        o_publish,
        output t_entry      o_next
    );

    logic [31:0] elapsed;
    logic [32:0] diff;
    logic [32:0] mag;
    logic        beat_due;

    always_comb begin
        elapsed  = i_smp.now - i_cur.stamp;
        diff     = {i_smp.analog[31], i_smp.analog} - {i_cur.analog[31], i_cur.analog};
        mag      = diff[32] ? (33'd0 - diff) : diff;
        beat_due = (i_smp.period != 24'd0) && (elapsed >= {8'd0, i_smp.period});

        o_publish = 1'b0;
        o_next    = i_cur;

        case (i_smp.policy)
            POL_ON_CHANGE: begin
                if (!i_ever || (i_cur.level != i_smp.level)) begin
                    o_publish    = 1'b1;
                    o_next.level = i_smp.level;
                    o_next.stamp = i_smp.now;
                end else if (beat_due) begin
                    // heartbeat: level kept
                    o_publish    = 1'b1;
                    o_next.stamp = i_smp.now;
                end
            end
            POL_ON_THRESHOLD: begin
                if (!i_ever || (mag >= {2'b00, i_smp.thr}) || beat_due) begin
                    o_publish     = 1'b1;
                    o_next.analog = i_smp.analog;
                    o_next.stamp  = i_smp.now;
                end
            end
            POL_PERIODIC: begin
                if (!i_ever || (elapsed >= {8'd0, i_limit})) begin
                    o_publish    = 1'b1;
                    o_next.level = i_smp.level;
                    o_next.stamp = i_smp.now;
                end
            end
            POL_CONTINUOUS: begin
                o_publish    = 1'b1;
                o_next.stamp = i_smp.now;
            end
            POL_ON_UPDATE: begin
                o_publish     = 1'b1;
                o_next.level  = i_smp.level;
                o_next.analog = i_smp.analog;
                o_next.stamp  = i_smp.now;
            end
            default: begin
                o_publish = 1'b0;
            end
        endcase
    end

endmodule

/* sv/per_topic_publish_filter.sv */
// Accepted beats are registered into stage 1, which decides on the topic state,
// and their results then into the output register. Throughput: one beat per cycle
// while i_out_stall does not hold the output; back-to-back beats on one topic are
// served by a bypass of the entry being written. Reset (synchronous, active low)
// empties the pipeline and clears the per-topic sent flags; a topic never sent reads as all-zero state.
module per_topic_publish_filter
    import ptpf_pkg::*;
    #(
        parameter int TOPICS = 32
    )
    (
        input  logic        i_clk,
        input  logic        i_rst_n,
        input  logic        i_in_valid,
        output logic        o_in_stall,
        input  logic [7:0]  i_topic_index,
        input  logic [2:0]  i_policy_mode,
        input  logic [23:0] i_period_ms,
        input  logic [30:0] i_delta_threshold,
        input  logic signed [31:0] i_analog_value,
        input  logic [7:0]  i_digital_level,
        input  logic [31:0] i_time_now_ms,
        output logic        o_out_valid,
        input  logic        i_out_stall,
        output logic        o_publish
    );

    localparam int         TW        = (TOPICS > 1) ? $clog2(TOPICS) : 1;
    localparam logic [8:0] TOPICS_9  = 9'(TOPICS);
    localparam logic [TW-1:0] LAST_T = TW'(TOPICS - 1);

    logic            w_accept;
    logic            w_s1_fire;
    logic            w_we;
    logic [TW-1:0]   w_topic_in;
    logic [27:0]     w_p9;
    logic [59:0]     w_prod;
    logic [23:0]     w_limit_in;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry          w_cur;
    t_entry          w_next;
    logic            w_ever;
    logic            w_pub;

    logic            r_s1_valid;
    t_sample         r_smp;
    logic [23:0]     r_limit;
    logic [TW-1:0]   r_topic;
    logic            r_fwd_hit;
    t_entry          r_fwd;
    logic [TOPICS-1:0] r_ever_sent;
    logic            r_out_valid;
    logic            r_pub;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_s1_fire  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_fire;
    assign w_we       = w_s1_fire && w_pub;

    assign w_topic_in = ({1'b0, i_topic_index} >= TOPICS_9) ? LAST_T : TW'(i_topic_index);

    // 90% of the period: (9p) / 10 by reciprocal
    assign w_p9       = {1'b0, i_period_ms, 3'b000} + {4'd0, i_period_ms};
    assign w_prod     = {32'd0, w_p9} * {28'd0, RECIP10};
    assign w_limit_in = w_prod[RECIP10_SHIFT +: 24];

    ptpf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOPICS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_topic),
        .i_wdata (w_next),
        .i_re    (w_accept),
        .i_raddr (w_topic_in),
        .o_rdata (w_rdata)
    );

    assign w_ever = r_ever_sent[r_topic];

    always_comb begin
        if (!w_ever) begin
            w_cur = '0;
        end else if (r_fwd_hit) begin
            w_cur = r_fwd;
        end else begin
            w_cur = w_rdata;
        end
    end

    ptpf_decide u_decide (
        .i_smp     (r_smp),
        .i_limit   (r_limit),
        .i_ever    (w_ever),
        .i_cur     (w_cur),
        .o_publish (w_pub),
        .o_next    (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_ever_sent <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= w_we && (r_topic == w_topic_in);
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end
            if (w_we) begin
                r_ever_sent[r_topic] <= 1'b1;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp.policy <= i_policy_mode;
            r_smp.period <= i_period_ms;
            r_smp.thr    <= i_delta_threshold;
            r_smp.analog <= i_analog_value;
            r_smp.level  <= i_digital_level;
            r_smp.now    <= i_time_now_ms;
            r_limit      <= w_limit_in;
            r_topic      <= w_topic_in;
            r_fwd        <= w_next;
        end
        if (w_s1_fire) begin
            r_pub <= w_pub;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_publish   = r_pub;

    a_unknown_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_smp.policy != POL_ON_CHANGE && r_smp.policy != POL_ON_THRESHOLD
         && r_smp.policy != POL_PERIODIC && r_smp.policy != POL_CONTINUOUS
         && r_smp.policy != POL_ON_UPDATE) |-> !w_we)
        else $error("unknown policy wrote topic state");

    a_write_marks_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_ever_sent[$past(r_topic)])
        else $error("written topic not marked as sent");

    a_bypass_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("bypass live with empty stage");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked beat");

endmodule
